// ===== src/plst_pkg.sv =====
`timescale 1ns / 1ps
package plst_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W   = 32;
  localparam int RANK_W   = 8;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_PORT_W = 8;
  // rank compares run one bit wider so that fill + 1 cannot wrap
  localparam int EXT_W    = RANK_W + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 3'd0,
    CMD_APPEND      = 3'd1,
    CMD_REMOVE      = 3'd2,
    CMD_REMOVE_LAST = 3'd3,
    CMD_READ        = 3'd4,
    CMD_OVERWRITE   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANK  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_TAKE_PREV = 2'd1,
    CELL_TAKE_NEXT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_op_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;
  } plst_result_t;

endpackage

// ===== src/plst_cell.sv =====
`timescale 1ns / 1ps
module plst_cell (
  input  logic                    clk,
  input  plst_pkg::cell_op_t      op,
  input  logic [plst_pkg::WORD_W-1:0] prev_word,
  input  logic [plst_pkg::WORD_W-1:0] next_word,
  input  logic [plst_pkg::WORD_W-1:0] new_word,
  output logic [plst_pkg::WORD_W-1:0] word
);
  import plst_pkg::*;

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;

  always_comb begin
    case (op)
      CELL_HOLD:      word_nxt = word_r;
      CELL_TAKE_PREV: word_nxt = prev_word;
      CELL_TAKE_NEXT: word_nxt = next_word;
      CELL_LOAD:      word_nxt = new_word;
      default:        word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

// ===== src/plst_ctrl.sv =====
`timescale 1ns / 1ps
module plst_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             fire,
  input  logic [plst_pkg::CMD_W-1:0]       cmd,
  input  logic [plst_pkg::RANK_W-1:0]      rank,
  output plst_pkg::cell_op_t               ops [plst_pkg::CAPACITY],
  output plst_pkg::plst_result_t           res
);
  import plst_pkg::*;

  logic [COUNT_W-1:0] fill_r;
  logic [COUNT_W-1:0] fill_nxt;

  logic [EXT_W-1:0] rank_ext;
  logic [EXT_W-1:0] pos_ext;
  logic [EXT_W-1:0] fill_ext;
  logic             rank_zero;
  logic             full;
  logic             empty;
  logic             do_insert;
  logic             do_append;
  logic             do_remove;
  logic             do_write;

  assign rank_ext  = EXT_W'(rank);
  assign pos_ext   = rank_ext - EXT_W'(1);
  assign fill_ext  = EXT_W'(fill_r);
  assign rank_zero = (rank == '0);
  assign full      = (fill_r == COUNT_W'(CAPACITY));
  assign empty     = (fill_r == '0);

  always_comb begin
    res.status = ST_OK;
    res.rd_en  = 1'b0;
    res.rd_idx = IDX_W'(pos_ext);
    fill_nxt   = fill_r;
    do_insert  = 1'b0;
    do_append  = 1'b0;
    do_remove  = 1'b0;
    do_write   = 1'b0;
    case (cmd_t'(cmd))
      CMD_INSERT: begin
        if (rank_zero || rank_ext > fill_ext + EXT_W'(1)) begin
          res.status = ST_RANK;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          do_insert = 1'b1;
          fill_nxt  = fill_r + COUNT_W'(1);
        end
      end
      CMD_APPEND: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          do_append = 1'b1;
          fill_nxt  = fill_r + COUNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (rank_zero || rank_ext > fill_ext) begin
          res.status = ST_RANK;
        end else begin
          do_remove = 1'b1;
          res.rd_en = 1'b1;
          fill_nxt  = fill_r - COUNT_W'(1);
        end
      end
      CMD_REMOVE_LAST: begin
        res.rd_idx = IDX_W'(fill_r - COUNT_W'(1));
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.rd_en = 1'b1;
          fill_nxt  = fill_r - COUNT_W'(1);
        end
      end
      CMD_READ, CMD_OVERWRITE: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (rank_zero || rank_ext > fill_ext) begin
          res.status = ST_RANK;
        end else if (cmd_t'(cmd) == CMD_READ) begin
          res.rd_en = 1'b1;
        end else begin
          do_write = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = fill_nxt;
  end

  // per-cell steering: each cell looks only at its own index
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ops[i] = CELL_HOLD;
      if (fire) begin
        if (do_insert) begin
          if (EXT_W'(i) == pos_ext) begin
            ops[i] = CELL_LOAD;
          end else if (EXT_W'(i) > pos_ext && EXT_W'(i) <= fill_ext) begin
            ops[i] = CELL_TAKE_PREV;
          end
        end else if (do_append) begin
          if (EXT_W'(i) == fill_ext) begin
            ops[i] = CELL_LOAD;
          end
        end else if (do_remove) begin
          if (EXT_W'(i) >= pos_ext && EXT_W'(i) + EXT_W'(1) < fill_ext) begin
            ops[i] = CELL_TAKE_NEXT;
          end
        end else if (do_write) begin
          if (EXT_W'(i) == pos_ext) begin
            ops[i] = CELL_LOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (fire) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== src/positional_list_store_unit.sv =====
`timescale 1ns / 1ps
// Bounded list of up to CAPACITY signed 32-bit words addressed by 1-based rank.
// Commands insert, append, remove at a rank, remove the last entry, read and
// overwrite; each returns one result with the word read or removed (zero
// otherwise), a status code and the entry count after the command. Every
// command takes effect at once: the list is a row of cells that each load
// from their front or back neighbor at once, so an insert or remove shifts the
// whole list at once, and a new command is taken every cycle while the output
// register is free or being emptied. The result appears in the cycle after
// the transfer in. Entries hold no reset value; only filled ranks are read.
module positional_list_store_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [plst_pkg::CMD_W-1:0]            in_cmd,
  input  logic [plst_pkg::RANK_W-1:0]           in_rank,
  input  logic signed [plst_pkg::WORD_W-1:0]    in_word_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [plst_pkg::WORD_W-1:0]    out_word_out,
  output logic [plst_pkg::STATUS_W-1:0]         out_status,
  output logic [plst_pkg::COUNT_PORT_W-1:0]     out_entry_count
);
  import plst_pkg::*;

  logic          fire;
  cell_op_t      ops [CAPACITY];
  plst_result_t  res;
  logic [WORD_W-1:0] cell_words [CAPACITY];
  logic [WORD_W-1:0] new_word;
  logic [WORD_W-1:0] rd_word;

  logic                    out_valid_r;
  logic [WORD_W-1:0]       out_word_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic [COUNT_PORT_W-1:0] out_count_r;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign new_word = WORD_W'(unsigned'(in_word_in));

  plst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cmd   (in_cmd),
    .rank  (in_rank),
    .ops   (ops),
    .res   (res)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] prev_w;
    logic [WORD_W-1:0] next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid_prev
      assign prev_w = cell_words[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_mid_next
      assign next_w = cell_words[g+1];
    end
    plst_cell u_cell (
      .clk       (clk),
      .op        (ops[g]),
      .prev_word (prev_w),
      .next_word (next_w),
      .new_word  (new_word),
      .word      (cell_words[g])
    );
  end

  assign rd_word = res.rd_en ? cell_words[res.rd_idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_word_r   <= rd_word;
      out_status_r <= res.status;
      out_count_r  <= COUNT_PORT_W'(res.count);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_word_out    = signed'(out_word_r);
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r <= COUNT_PORT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_FULL |->
      out_count_r == COUNT_PORT_W'(CAPACITY) && out_word_r == '0)
    else $error("full status without a full list");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_EMPTY |->
      out_count_r == '0 && out_word_r == '0)
    else $error("empty status without an empty list");

  a_fail_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.status != ST_OK |=> out_count_r == $past(COUNT_PORT_W'(res.count)))
    else $error("failed command changed the count");

endmodule
